@@ design/postfix_expression_evaluator_core_defines.svh @@
// Assertion macros for the postfix evaluator checker.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define PFX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PFX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/pfx_eval_pkg.sv @@
// Shared types and constants of the postfix evaluator.
package pfx_eval_pkg;

   localparam int DATA_W = 32;
   localparam int STEP_W = 5;    // counts the 32 steps of multiply and divide

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_UNDERFLOW = 3'd1;
   localparam logic [2:0] ST_OVERFLOW  = 3'd2;
   localparam logic [2:0] ST_UNKNOWN   = 3'd3;
   localparam logic [2:0] ST_DIVZERO   = 3'd4;
   localparam logic [2:0] ST_LEFTOVER  = 3'd5;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_Z  = 8'h5A;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_Z  = 8'h7A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;

   typedef logic [1:0] alu_op_type;
   localparam alu_op_type ALU_ADD = 2'd0;
   localparam alu_op_type ALU_SUB = 2'd1;
   localparam alu_op_type ALU_MUL = 2'd2;
   localparam alu_op_type ALU_DIV = 2'd3;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

endpackage

@@ design/pfx_eval_ifs.sv @@
// Valid/ready channel interfaces for expression characters and results.
interface pfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfx_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic        [2:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

@@ design/pfx_eval_alu.sv @@
// Shared arithmetic unit: registered add/subtract, 32-step multiply and divide.
module pfx_eval_alu
   import pfx_eval_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  alu_cmd_type       cmd,
   input  logic [DATA_W-1:0] opa,
   input  logic [DATA_W-1:0] opb,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   logic              busy_ff, busy_in;
   logic              fix_ff, fix_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   alu_op_type        op_ff, op_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] mcand_ff, mcand_in;
   logic [DATA_W-1:0] result_ff, result_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;

   always_comb begin
      busy_in   = busy_ff;
      fix_in    = 1'b0;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      acc_in    = acc_ff;
      quo_in    = quo_ff;
      mcand_in  = mcand_ff;
      result_in = result_ff;
      rem_sh    = {acc_ff, quo_ff[DATA_W-1]};
      diff      = rem_sh - {1'b0, mcand_ff};
      if (cmd.start) begin
         op_in  = cmd.op;
         cnt_in = '0;
         acc_in = '0;
         unique case (cmd.op)
            ALU_ADD: begin
               result_in = opa + opb;
               done_in   = 1'b1;
            end
            ALU_SUB: begin
               result_in = opa - opb;
               done_in   = 1'b1;
            end
            ALU_MUL: begin
               quo_in   = opb;
               mcand_in = opa;
               busy_in  = 1'b1;
            end
            ALU_DIV: begin
               // work on magnitudes, sign fixed at the end
               quo_in   = opa[DATA_W-1] ? (~opa + 1'b1) : opa;
               mcand_in = opb[DATA_W-1] ? (~opb + 1'b1) : opb;
               neg_in   = opa[DATA_W-1] ^ opb[DATA_W-1];
               busy_in  = 1'b1;
            end
            default: ;
         endcase
      end else if (busy_ff) begin
         if (op_ff == ALU_MUL) begin
            acc_in   = acc_ff + (quo_ff[0] ? mcand_ff : '0);
            mcand_in = {mcand_ff[DATA_W-2:0], 1'b0};
            quo_in   = {1'b0, quo_ff[DATA_W-1:1]};
         end else if (!diff[DATA_W]) begin
            acc_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            acc_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end else if (fix_ff) begin
         if (op_ff == ALU_MUL) begin
            result_in = acc_ff;
         end else begin
            result_in = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
         end
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      acc_ff    <= acc_in;
      quo_ff    <= quo_in;
      mcand_ff  <= mcand_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

@@ design/postfix_expression_evaluator_core.sv @@
// Postfix evaluator: one ASCII character per input word, one result word per expression.
// Characters arrive one word at a time; letters and digits push their code minus 48, and
// + - * / combine the two top values (left op right, 32-bit wrapping, division truncating
// toward zero). A word marked last causes one result word carrying the top value (0 on an
// empty stack) and the first error of the expression, after which the stack clears. An
// operand or an ignored character is handled in the cycle it is accepted; an operator
// passes through S_OPER and S_WAIT, and * and / run through the shared 32-step multiply/divide
// unit (a division by zero skips the unit and S_WAIT); a last word then passes through
// S_FIN to load the result register, and waits there while an earlier result is not yet
// taken. The stack is a one-read one-write memory of STACK_DEPTH entries; only entries
// below the fill count are used, so it needs no clearing after reset.
module postfix_expression_evaluator_core
   import pfx_eval_pkg::*;
#(
   parameter int STACK_DEPTH = 16
) (
   input  logic     clock,
   input  logic     reset,
   pfx_req_if.sink  req_chan,
   pfx_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_OPER = 3'd1;
   localparam logic [2:0] S_WAIT = 3'd2;
   localparam logic [2:0] S_FIN  = 3'd3;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        err_ff, err_in;
   logic              last_ff, last_in;
   alu_op_type        op_ff, op_in;
   logic [DATA_W-1:0] top_ff, top_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;

   logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;

   alu_cmd_type       alu_cmd;
   logic              alu_done;
   logic [DATA_W-1:0] alu_result;

   logic              accept;
   logic              is_alnum;
   logic              is_oper;
   logic [CNT_W-1:0]  count_m2;

   function automatic logic [2:0] keep_first(input logic [2:0] cur, input logic [2:0] code);
      keep_first = (cur == ST_OK) ? code : cur;
   endfunction

   assign accept   = req_chan.valid && (state_ff == S_IDLE);
   assign is_alnum = ((req_chan.symbol >= CH_ZERO) && (req_chan.symbol <= CH_NINE)) ||
                     ((req_chan.symbol >= CH_UP_A) && (req_chan.symbol <= CH_UP_Z)) ||
                     ((req_chan.symbol >= CH_LO_A) && (req_chan.symbol <= CH_LO_Z));
   assign is_oper  = (req_chan.symbol == CH_PLUS) || (req_chan.symbol == CH_MINUS) ||
                     (req_chan.symbol == CH_STAR) || (req_chan.symbol == CH_SLASH);
   assign count_m2 = count_ff - CNT_W'(2);
   // left operand slot; read every cycle, valid in the cycle after an operator word
   assign rd_addr  = count_m2[ADDR_W-1:0];

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      op_in         = op_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_addr;
      wr_data       = alu_result;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = op_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in  = req_chan.last;
               state_in = req_chan.last ? S_FIN : S_IDLE;
               if (is_alnum) begin
                  if (count_ff == CNT_W'(STACK_DEPTH)) begin
                     err_in = keep_first(err_ff, ST_OVERFLOW);
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[ADDR_W-1:0];
                     wr_data  = {{(DATA_W-8){1'b0}}, req_chan.symbol - CH_ZERO};
                     top_in   = wr_data;
                     count_in = count_ff + 1'b1;
                  end
               end else if (is_oper) begin
                  if (count_ff < CNT_W'(2)) begin
                     err_in = keep_first(err_ff, ST_UNDERFLOW);
                  end else begin
                     state_in = S_OPER;
                     priority case (req_chan.symbol)
                        CH_PLUS:  op_in = ALU_ADD;
                        CH_MINUS: op_in = ALU_SUB;
                        CH_STAR:  op_in = ALU_MUL;
                        default:  op_in = ALU_DIV;
                     endcase
                  end
               end else begin
                  err_in = keep_first(err_ff, ST_UNKNOWN);
               end
            end
         end
         S_OPER: begin
            if ((op_ff == ALU_DIV) && (top_ff == '0)) begin
               err_in   = keep_first(err_ff, ST_DIVZERO);
               wr_en    = 1'b1;
               wr_data  = '0;
               top_in   = '0;
               count_in = count_ff - 1'b1;
               state_in = last_ff ? S_FIN : S_IDLE;
            end else begin
               alu_cmd.start = 1'b1;
               state_in      = S_WAIT;
            end
         end
         S_WAIT: begin
            if (alu_done) begin
               wr_en    = 1'b1;
               top_in   = alu_result;
               count_in = count_ff - 1'b1;
               state_in = last_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = (count_ff != '0) ? top_ff : '0;
               if (err_ff != ST_OK) begin
                  rsp_status_in = err_ff;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_UNDERFLOW;
               end else if (count_ff > CNT_W'(1)) begin
                  rsp_status_in = ST_LEFTOVER;
               end else begin
                  rsp_status_in = ST_OK;
               end
               count_in = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      op_ff         <= op_in;
      top_ff        <= top_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   pfx_eval_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (rd_data_ff),
      .opb    (top_ff),
      .done   (alu_done),
      .result (alu_result)
   );

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.value  = rsp_value_ff;
   assign rsp_chan.status = rsp_status_ff;

endmodule

@@ design/pfx_eval_checker.sv @@
// Port-level checks of the postfix evaluator, bound to the top level.
`include "postfix_expression_evaluator_core_defines.svh"

module pfx_eval_checker
   import pfx_eval_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value,
   input logic [2:0]  rsp_status
);

   `PFX_ASSERT_NOW(a_status_range, clock, reset, rsp_valid, rsp_status <= ST_LEFTOVER, "status code out of range")
   `PFX_ASSERT_NEXT(a_last_blocks, clock, reset, req_valid && req_ready && req_last, !req_ready, "ready after last word")
   `PFX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value) && $stable(rsp_status), "stalled result changed")
   `PFX_ASSERT_NEXT(a_reset_clear, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind postfix_expression_evaluator_core pfx_eval_checker u_pfx_eval_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .req_last   (req_chan.last),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.value),
   .rsp_status (rsp_chan.status)
);

@@ dv/tb.sv @@
// Testbench for the postfix expression evaluator core.
`timescale 1ns / 100ps

module tb;
   import pfx_eval_pkg::*;

   localparam int STACK_DEPTH = 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_CHARS = 360;

   typedef struct {
      logic signed [31:0] value;
      logic        [2:0]  status;
   } eval_result_type;

   logic clock;
   logic reset;

   pfx_req_if req_bus ();
   pfx_rsp_if rsp_bus ();

   postfix_expression_evaluator_core #(
      .STACK_DEPTH(STACK_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // evaluator state mirrored by the testbench
   logic [31:0]     eval_stack [STACK_DEPTH];
   int              eval_depth = 0;
   logic [2:0]      eval_error = ST_OK;
   eval_result_type pending_results [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   int chars_sent = 0;
   int exprs_sent = 0;
   int results_checked = 0;
   int cycle_count = 0;
   int status_seen [8];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
         $display("tb failed");
         $finish;
      end
   end

   function automatic bit is_operand(logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_LO_A && c <= CH_LO_Z);
   endfunction

   function automatic void note_error(logic [2:0] code);
      if (eval_error == ST_OK)
         eval_error = code;
   endfunction

   // Division on magnitudes so that the most negative value over -1 wraps.
   function automatic logic [31:0] quotient_trunc(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_n;
      logic [31:0] mag_d;
      logic [31:0] quo;
      mag_n = num[31] ? (32'd0 - num) : num;
      mag_d = den[31] ? (32'd0 - den) : den;
      quo = mag_n / mag_d;
      return (num[31] != den[31]) ? (32'd0 - quo) : quo;
   endfunction

   function automatic void eval_symbol(logic [7:0] c, logic lst);
      logic [31:0]     rhs;
      logic [31:0]     lhs;
      logic [31:0]     res;
      eval_result_type r;
      if (is_operand(c)) begin
         if (eval_depth >= STACK_DEPTH) begin
            note_error(ST_OVERFLOW);
         end else begin
            eval_stack[eval_depth] = {24'd0, c} - 32'd48;
            eval_depth++;
         end
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
         if (eval_depth < 2) begin
            note_error(ST_UNDERFLOW);
         end else begin
            rhs = eval_stack[eval_depth-1];
            lhs = eval_stack[eval_depth-2];
            eval_depth -= 2;
            case (c)
               CH_PLUS:  res = lhs + rhs;
               CH_MINUS: res = lhs - rhs;
               CH_STAR:  res = lhs * rhs;
               default: begin
                  if (rhs == 32'd0) begin
                     note_error(ST_DIVZERO);
                     res = 32'd0;
                  end else begin
                     res = quotient_trunc(lhs, rhs);
                  end
               end
            endcase
            eval_stack[eval_depth] = res;
            eval_depth++;
         end
      end else begin
         note_error(ST_UNKNOWN);
      end

      if (lst) begin
         r.value = (eval_depth > 0) ? eval_stack[eval_depth-1] : 32'd0;
         if (eval_error != ST_OK)
            r.status = eval_error;
         else if (eval_depth == 0)
            r.status = ST_UNDERFLOW;
         else if (eval_depth > 1)
            r.status = ST_LEFTOVER;
         else
            r.status = ST_OK;
         pending_results.push_back(r);
         eval_depth = 0;
         eval_error = ST_OK;
      end
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input logic [7:0] sym, input logic lst);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.symbol <= sym;
      req_bus.last   <= lst;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      eval_symbol(sym, lst);
      chars_sent++;
      if (lst)
         exprs_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(s[i], i == s.len() - 1);
   endtask

   task automatic wait_results_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      eval_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result word, value %0d status %0d",
                        $time, rsp_bus.value, rsp_bus.status);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               status_seen[want.status]++;
               if (rsp_bus.value !== want.value) begin
                  $display("%0t: value mismatch, expected %0d, got %0d",
                           $time, want.value, rsp_bus.value);
                  fail_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, rsp_bus.status);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic logic [7:0] random_operand();
      case ($urandom_range(0, 9))
         0:       return CH_ZERO;
         1:       return CH_ZERO + 8'd1;
         2, 3, 4: return 8'($urandom_range(CH_ZERO, CH_NINE));
         5, 6:    return 8'($urandom_range(CH_UP_A, CH_UP_Z));
         default: return 8'($urandom_range(CH_LO_A, CH_LO_Z));
      endcase
   endfunction

   function automatic logic [7:0] random_operator();
      case ($urandom_range(0, 3))
         0:       return CH_PLUS;
         1:       return CH_MINUS;
         2:       return CH_STAR;
         default: return CH_SLASH;
      endcase
   endfunction

   task automatic send_random_expression();
      logic [7:0] expr [$];
      int         kind;
      int         n_opnd;
      int         pushed;
      int         depth;
      int         len;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         // well formed, occasionally deep enough to overflow
         n_opnd = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
         pushed = 0;
         depth = 0;
         while (pushed < n_opnd || depth > 1) begin
            if (pushed < n_opnd && (depth < 2 || $urandom_range(0, 1))) begin
               expr.push_back(random_operand());
               pushed++;
               depth++;
            end else begin
               expr.push_back(random_operator());
               depth--;
            end
         end
      end else if (kind < 90) begin
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
               0, 1:    expr.push_back(8'($urandom_range(0, 255)));
               2, 3, 4, 5, 6, 7, 8, 9, 10: expr.push_back(random_operand());
               default: expr.push_back(random_operator());
            endcase
         end
      end else begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++)
            expr.push_back(8'($urandom_range(0, 255)));
      end
      foreach (expr[i])
         send_word(expr[i], i == expr.size() - 1);
   endtask

   task automatic test_operators();
      // all four operators, negative quotient truncated toward zero
      send_text("38-2/7*4+1-");
      send_text("94/");
   endtask

   task automatic test_error_cases();
      send_word(8'h00, 1'b1);        // unknown, stack empty at end
      send_text("+");                // underflow only
      send_text("50/");              // divide by zero
      send_text("12");               // leftover values
      // underflow first, later unknown code 255 must not replace it
      send_word(CH_PLUS, 1'b0);
      send_word(CH_LO_A, 1'b0);
      send_word(8'hFF, 1'b1);
   endtask

   task automatic test_wraparound();
      // builds 2**31, which wraps to the most negative value, then divides by -1
      send_text("pp*pp**p*2*01-/");
   endtask

   task automatic test_overflow();
      for (int i = 0; i <= STACK_DEPTH; i++)
         send_word(CH_LO_Z, 1'b0);
      send_word(8'h80, 1'b1);
   endtask

   task automatic test_random_expressions();
      int idle_set [5]  = '{0, 61, 0, 8, 0};
      int stall_set [5] = '{0, 0, 61, 8, 0};
      int target;
      target = chars_sent;
      for (int p = 0; p < 5; p++) begin
         idle_pct = idle_set[p];
         stall_pct = stall_set[p];
         target += PHASE_CHARS;
         while (chars_sent < target)
            send_random_expression();
         // hold off until the evaluator has returned everything
         wait_results_drained();
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.symbol <= 8'd0;
      req_bus.last   <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_operators();
      test_error_cases();
      test_wraparound();
      test_overflow();
      wait_results_drained();
      test_random_expressions();

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         fail_count++;
      end
      $display("%0d characters in %0d expressions, %0d results checked",
               chars_sent, exprs_sent, results_checked);
      $display("status counts ok/under/over/unknown/div0/leftover: %0d %0d %0d %0d %0d %0d",
               status_seen[ST_OK], status_seen[ST_UNDERFLOW], status_seen[ST_OVERFLOW],
               status_seen[ST_UNKNOWN], status_seen[ST_DIVZERO], status_seen[ST_LEFTOVER]);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
